[rtl/mbps_pkg.sv]
// Package for the motor button press sequencer.
// Holds the word types, opcode and command state codes, and register indexes.
// No dependencies; every other file in rtl uses it.
package mbps_pkg;

  // Opcodes of an input word.
  localparam logic [2:0] OP_TICK     = 3'd0;
  localparam logic [2:0] OP_HOST_CW  = 3'd1;
  localparam logic [2:0] OP_HOST_CCW = 3'd2;
  localparam logic [2:0] OP_HOST_STOP = 3'd3;
  localparam logic [2:0] OP_KNOB     = 3'd4;

  // Command machine states, as reported in command_state.
  localparam logic [2:0] CMD_REST = 3'd0;
  localparam logic [2:0] CMD_CW   = 3'd1;
  localparam logic [2:0] CMD_CCW  = 3'd2;
  localparam logic [2:0] CMD_OFF  = 3'd3;
  localparam logic [2:0] CMD_ON   = 3'd4;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_TICKS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RUN_TICKS      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KNOB_THRESHOLD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BUTTON_RELOAD  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_RELOAD   = 3'd4;
  localparam int unsigned CFG_DATA_W = 10;

  // Register reset values.
  localparam logic [7:0] PRESS_TICKS_RST    = 8'd4;
  localparam logic [7:0] RUN_TICKS_RST      = 8'd20;
  localparam logic [9:0] KNOB_THRESHOLD_RST = 10'd500;
  localparam logic [7:0] BUTTON_RELOAD_RST  = 8'd8;
  localparam logic [7:0] LIMIT_RELOAD_RST   = 8'd4;

  // Lamp and blink patterns of a timed run.
  localparam logic [1:0] LAMP_CW  = 2'b10;
  localparam logic [1:0] LAMP_CCW = 2'b01;

  typedef struct packed {
    logic [2:0] opcode;
    logic       button_one_level;
    logic       button_two_level;
    logic       sensor_one_level;
    logic       sensor_two_level;
    logic       drive_running;
    logic       drive_cw_mode;
    logic       knob_channel;
    logic [9:0] knob_level;
  } in_word_t;

  typedef struct packed {
    logic       dir_press_low;
    logic       power_press_low;
    logic [2:0] command_state;
    logic       execute_mode;
    logic       run_active;
    logic       led_one;
    logic       led_two;
    logic [3:0] blink_mask;
    logic       limit_one;
    logic       limit_two;
    logic       button_one_event;
    logic       button_two_event;
  } out_word_t;

  // Class of a word as decoded by the front end.
  typedef enum logic [2:0] {
    CLS_TICK,
    CLS_HOST_CW,
    CLS_HOST_CCW,
    CLS_HOST_STOP,
    CLS_KNOB,
    CLS_NONE
  } op_class_t;

  // Queue entry handed from the front end to the back end.
  typedef struct packed {
    op_class_t  cls;
    logic       button_one_level;
    logic       button_two_level;
    logic       sensor_one_level;
    logic       sensor_two_level;
    logic       drive_running;
    logic       drive_cw_mode;
    logic       knob_channel;
    logic [9:0] knob_level;
  } cmd_item_t;

  // Queue status seen by the front end.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

[rtl/mbps_front.sv]
// Front end of the motor button press sequencer: accepts input words and
// classifies them by opcode into queue entries.
// Depends on mbps_pkg.
module mbps_front (
  input  logic                    in_valid,
  output logic                    in_stall,
  input  mbps_pkg::in_word_t      in_word,
  input  mbps_pkg::queue_status_t q_status,
  output logic                    q_push,
  output mbps_pkg::cmd_item_t     q_item
);

  mbps_pkg::op_class_t cls;

  always_comb begin
    unique case (in_word.opcode)
      mbps_pkg::OP_TICK:      cls = mbps_pkg::CLS_TICK;
      mbps_pkg::OP_HOST_CW:   cls = mbps_pkg::CLS_HOST_CW;
      mbps_pkg::OP_HOST_CCW:  cls = mbps_pkg::CLS_HOST_CCW;
      mbps_pkg::OP_HOST_STOP: cls = mbps_pkg::CLS_HOST_STOP;
      mbps_pkg::OP_KNOB:      cls = mbps_pkg::CLS_KNOB;
      default:                cls = mbps_pkg::CLS_NONE;
    endcase
  end

  assign in_stall = q_status.full;
  assign q_push   = in_valid & ~q_status.full;

  always_comb begin
    q_item.cls              = cls;
    q_item.button_one_level = in_word.button_one_level;
    q_item.button_two_level = in_word.button_two_level;
    q_item.sensor_one_level = in_word.sensor_one_level;
    q_item.sensor_two_level = in_word.sensor_two_level;
    q_item.drive_running    = in_word.drive_running;
    q_item.drive_cw_mode    = in_word.drive_cw_mode;
    q_item.knob_channel     = in_word.knob_channel;
    q_item.knob_level       = in_word.knob_level;
  end

endmodule

[rtl/mbps_queue.sv]
// Two-entry queue between the front end and the back end of the sequencer.
// Depends on mbps_pkg for the entry type.
module mbps_queue (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  mbps_pkg::cmd_item_t     push_item,
  input  logic                    pop,
  output mbps_pkg::cmd_item_t     head_item,
  output mbps_pkg::queue_status_t status
);

  mbps_pkg::cmd_item_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  assign head_item    = mem_r[rd_ptr_r];
  assign status.full  = count_r[1];
  assign status.empty = (count_r == 2'd0);

endmodule

[rtl/mbps_back.sv]
// Back end of the sequencer: configuration registers, debounce counters,
// the command machine and run countdown, and the registered output word.
// Depends on mbps_pkg.
module mbps_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [mbps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mbps_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  mbps_pkg::queue_status_t            q_status,
  input  mbps_pkg::cmd_item_t                q_item,
  output logic                               q_pop,
  output logic                               out_valid,
  input  logic                               out_stall,
  output mbps_pkg::out_word_t                out_word
);

  typedef struct packed {
    logic [7:0] press_ticks;
    logic [7:0] run_ticks;
    logic [9:0] knob_threshold;
    logic [7:0] button_reload;
    logic [7:0] limit_reload;
  } cfg_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] press_cnt;
    logic [7:0] pre_cnt;
    logic [7:0] btn_one_cnt;
    logic [7:0] btn_two_cnt;
    logic [7:0] lim_one_cnt;
    logic [7:0] lim_two_cnt;
    logic [7:0] run_left;
    logic       run_flag;
    logic       host_test;
    logic       dir_cw;
    logic       dir_ccw;
    logic [1:0] lim_flags;
    logic [1:0] lamp_bits;
    logic [3:0] blink_bits;
    logic       exec_flag;
    logic [1:0] knob_armed;
    logic       dir_low;
    logic       power_low;
  } seq_state_t;

  cfg_t                cfg_r, cfg_nxt;
  seq_state_t          st_r, st_nxt;
  seq_state_t          st_rst;
  logic                out_valid_r, out_valid_nxt;
  mbps_pkg::out_word_t out_word_r, out_word_nxt;
  logic                take;

  // Any request reloads both delays; a new command only lands from idle.
  function automatic seq_state_t do_request(seq_state_t s, logic [2:0] cmd,
                                            logic [7:0] pt);
    seq_state_t r;
    r = s;
    r.exec_flag = 1'b1;
    if (r.cmd == mbps_pkg::CMD_REST) begin
      r.cmd = cmd;
    end
    r.press_cnt = pt;
    r.pre_cnt   = pt;
    return r;
  endfunction

  function automatic seq_state_t do_arm(seq_state_t s, logic cw, logic [7:0] rt,
                                        logic [7:0] pt);
    seq_state_t r;
    r = s;
    r.run_flag   = 1'b1;
    r.run_left   = rt;
    r.dir_cw     = cw;
    r.dir_ccw    = ~cw;
    r.blink_bits = {2'b00, cw ? mbps_pkg::LAMP_CW : mbps_pkg::LAMP_CCW};
    r.lamp_bits  = cw ? mbps_pkg::LAMP_CW : mbps_pkg::LAMP_CCW;
    return do_request(r, cw ? mbps_pkg::CMD_CW : mbps_pkg::CMD_CCW, pt);
  endfunction

  // Hold a press line while the hold count lasts, then release and go idle.
  // Returns the new state, with the new line level in power_low or dir_low.
  function automatic seq_state_t do_hold(seq_state_t s, logic power_line);
    seq_state_t r;
    logic       line;
    r = s;
    if (r.press_cnt != 8'd0) begin
      line = 1'b1;
    end else begin
      line  = 1'b0;
      r.cmd = mbps_pkg::CMD_REST;
    end
    r.press_cnt = r.press_cnt - 8'd1;
    if (power_line) begin
      r.power_low = line;
    end else begin
      r.dir_low = line;
    end
    return r;
  endfunction

  function automatic seq_state_t do_power(seq_state_t s, logic need);
    seq_state_t r;
    r = s;
    if (r.pre_cnt == 8'd0) begin
      if (need) begin
        r = do_hold(r, 1'b1);
      end else begin
        r.cmd = mbps_pkg::CMD_REST;
      end
    end else begin
      r.pre_cnt = r.pre_cnt - 8'd1;
    end
    return r;
  endfunction

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        mbps_pkg::CFG_PRESS_TICKS:    cfg_nxt.press_ticks    = cfg_wdata[7:0];
        mbps_pkg::CFG_RUN_TICKS:      cfg_nxt.run_ticks      = cfg_wdata[7:0];
        mbps_pkg::CFG_KNOB_THRESHOLD: cfg_nxt.knob_threshold = cfg_wdata;
        mbps_pkg::CFG_BUTTON_RELOAD:  cfg_nxt.button_reload  = cfg_wdata[7:0];
        mbps_pkg::CFG_LIMIT_RELOAD:   cfg_nxt.limit_reload   = cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // State after reset: idle, delays and debounce counts at their defaults.
  always_comb begin
    st_rst             = '0;
    st_rst.cmd         = mbps_pkg::CMD_REST;
    st_rst.press_cnt   = mbps_pkg::PRESS_TICKS_RST;
    st_rst.pre_cnt     = mbps_pkg::PRESS_TICKS_RST;
    st_rst.btn_one_cnt = mbps_pkg::BUTTON_RELOAD_RST;
    st_rst.btn_two_cnt = mbps_pkg::BUTTON_RELOAD_RST;
    st_rst.lim_one_cnt = mbps_pkg::LIMIT_RELOAD_RST;
    st_rst.lim_two_cnt = mbps_pkg::LIMIT_RELOAD_RST;
  end

  assign take  = ~q_status.empty & (~out_valid_r | ~out_stall);
  assign q_pop = take;

  always_comb begin
    seq_state_t n;
    logic       ev1;
    logic       ev2;
    logic [1:0] kbit;
    logic       kactive;
    n    = st_r;
    ev1  = 1'b0;
    ev2  = 1'b0;
    kbit = q_item.knob_channel ? 2'b10 : 2'b01;
    kactive = q_item.knob_channel ? st_r.dir_ccw : st_r.dir_cw;

    case (q_item.cls)
      mbps_pkg::CLS_TICK: begin
        // Push button one: cancel to idle.
        if (!q_item.button_one_level) begin
          if (n.btn_one_cnt == 8'd0) begin
            ev1 = 1'b1;
            n.lamp_bits[0] = 1'b1;
            n.blink_bits   = 4'd0;
            n.exec_flag    = 1'b0;
            n.cmd          = mbps_pkg::CMD_REST;
            n.press_cnt    = cfg_r.press_ticks;
            n.pre_cnt      = cfg_r.press_ticks;
          end
          n.btn_one_cnt = n.btn_one_cnt - 8'd1;
        end else begin
          n.btn_one_cnt = cfg_r.button_reload;
        end
        // Push button two: request off.
        if (!q_item.button_two_level) begin
          if (n.btn_two_cnt == 8'd0) begin
            ev2 = 1'b1;
            n.lamp_bits[1] = 1'b1;
            n.blink_bits   = 4'd0;
            n = do_request(n, mbps_pkg::CMD_OFF, cfg_r.press_ticks);
          end
          n.btn_two_cnt = n.btn_two_cnt - 8'd1;
        end else begin
          n.btn_two_cnt = cfg_r.button_reload;
        end
        // Limit sensor one stops a clockwise run.
        if (q_item.sensor_one_level) begin
          if (n.lim_one_cnt == 8'd0) begin
            n.lim_flags[0] = 1'b1;
            n.lamp_bits[0] = 1'b1;
            n.blink_bits   = 4'd0;
            if (q_item.drive_running && n.dir_cw) begin
              n.exec_flag = 1'b1;
              if (n.cmd == mbps_pkg::CMD_REST) begin
                n.cmd = mbps_pkg::CMD_OFF;
              end
            end
            n.press_cnt = cfg_r.press_ticks;
            n.pre_cnt   = cfg_r.press_ticks;
          end
          n.lim_one_cnt = n.lim_one_cnt - 8'd1;
        end else begin
          n.lim_flags[0] = 1'b0;
          n.lim_one_cnt  = cfg_r.limit_reload;
        end
        // Limit sensor two stops a counterclockwise run.
        if (q_item.sensor_two_level) begin
          if (n.lim_two_cnt == 8'd0) begin
            n.lim_flags[1] = 1'b1;
            n.lamp_bits[1] = 1'b1;
            n.blink_bits   = 4'd0;
            if (q_item.drive_running && n.dir_ccw) begin
              n.exec_flag = 1'b1;
              if (n.cmd == mbps_pkg::CMD_REST) begin
                n.cmd = mbps_pkg::CMD_OFF;
              end
            end
            n.press_cnt = cfg_r.press_ticks;
            n.pre_cnt   = cfg_r.press_ticks;
          end
          n.lim_two_cnt = n.lim_two_cnt - 8'd1;
        end else begin
          n.lim_flags[1] = 1'b0;
          n.lim_two_cnt  = cfg_r.limit_reload;
        end

        unique case (n.cmd)
          mbps_pkg::CMD_REST: begin
            n.dir_low   = 1'b0;
            n.power_low = 1'b0;
            n.press_cnt = cfg_r.press_ticks;
            n.pre_cnt   = cfg_r.press_ticks;
          end
          mbps_pkg::CMD_CW: begin
            if (!q_item.drive_cw_mode) begin
              n = do_hold(n, 1'b0);
            end else begin
              n.cmd = mbps_pkg::CMD_ON;
            end
          end
          mbps_pkg::CMD_CCW: begin
            if (q_item.drive_cw_mode) begin
              n = do_hold(n, 1'b0);
            end else begin
              n.press_cnt = cfg_r.press_ticks;
              n.pre_cnt   = cfg_r.press_ticks;
              n.cmd       = mbps_pkg::CMD_ON;
            end
          end
          mbps_pkg::CMD_OFF: n = do_power(n, q_item.drive_running);
          mbps_pkg::CMD_ON:  n = do_power(n, ~q_item.drive_running);
          default: begin
            n.cmd       = mbps_pkg::CMD_REST;
            n.press_cnt = cfg_r.press_ticks;
            n.pre_cnt   = cfg_r.press_ticks;
          end
        endcase

        // Run countdown; an expired knob run forces the off command.
        if (n.run_left != 8'd0 && n.run_flag) begin
          n.run_left = n.run_left - 8'd1;
        end else if (n.run_flag && !n.host_test) begin
          n.run_flag = 1'b0;
          n.cmd      = mbps_pkg::CMD_OFF;
        end
      end
      mbps_pkg::CLS_HOST_CW: begin
        n.host_test = 1'b1;
        n.lim_flags = 2'b00;
        n = do_arm(n, 1'b1, cfg_r.run_ticks, cfg_r.press_ticks);
      end
      mbps_pkg::CLS_HOST_CCW: begin
        n.host_test = 1'b1;
        n = do_arm(n, 1'b0, cfg_r.run_ticks, cfg_r.press_ticks);
      end
      mbps_pkg::CLS_HOST_STOP: begin
        n.host_test  = 1'b0;
        n.blink_bits = 4'd0;
        n = do_request(n, mbps_pkg::CMD_OFF, cfg_r.press_ticks);
      end
      mbps_pkg::CLS_KNOB: begin
        if (q_item.knob_level < cfg_r.knob_threshold) begin
          if ((n.knob_armed & kbit) != 2'b00) begin
            if (!kactive) begin
              n.knob_armed = n.knob_armed & ~kbit;
            end
          end else begin
            n.knob_armed = n.knob_armed | kbit;
            n = do_arm(n, ~q_item.knob_channel, cfg_r.run_ticks, cfg_r.press_ticks);
          end
        end else begin
          n.knob_armed = n.knob_armed | kbit;
          if (q_item.knob_channel) begin
            n.dir_ccw = 1'b0;
          end else begin
            n.dir_cw = 1'b0;
          end
        end
      end
      default: ;
    endcase

    st_nxt = take ? n : st_r;

    out_word_nxt.dir_press_low    = n.dir_low;
    out_word_nxt.power_press_low  = n.power_low;
    out_word_nxt.command_state    = n.cmd;
    out_word_nxt.execute_mode     = n.exec_flag;
    out_word_nxt.run_active       = n.run_flag;
    out_word_nxt.led_one          = n.lamp_bits[0];
    out_word_nxt.led_two          = n.lamp_bits[1];
    out_word_nxt.blink_mask       = n.blink_bits;
    out_word_nxt.limit_one        = n.lim_flags[0];
    out_word_nxt.limit_two        = n.lim_flags[1];
    out_word_nxt.button_one_event = ev1;
    out_word_nxt.button_two_event = ev2;
  end

  always_comb begin
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.press_ticks    <= mbps_pkg::PRESS_TICKS_RST;
      cfg_r.run_ticks      <= mbps_pkg::RUN_TICKS_RST;
      cfg_r.knob_threshold <= mbps_pkg::KNOB_THRESHOLD_RST;
      cfg_r.button_reload  <= mbps_pkg::BUTTON_RELOAD_RST;
      cfg_r.limit_reload   <= mbps_pkg::LIMIT_RELOAD_RST;
      st_r                 <= st_rst;
      out_valid_r          <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

[rtl/motor_button_press_sequencer.sv]
// Top level of the motor button press sequencer.
// Instantiates mbps_front, mbps_queue and mbps_back; depends on mbps_pkg.
//
// Usage: each input word carries an opcode (tick, host run clockwise, host
// run counterclockwise, host stop, knob sample) with the sampled button,
// sensor, drive status and knob levels. Every accepted word yields exactly
// one result word with the press line levels, the command state, the mode,
// run and lamp status, the debounced limit flags and the button events.
// Both channels use valid and stall; a word moves at an edge with valid high
// and stall low. The front end decodes the opcode and places the word in a
// two-entry queue; the back end pops it, updates all state and registers
// the result in the output register. One word per cycle is sustained while
// the receiver does not stall. When the receiver stalls, the output word
// holds, the queue fills, and in_stall rises once both entries are taken.
// The configuration port writes one register per cycle with cfg_we; the
// user must write it only while no word is in flight; the block does not
// enforce this. Synchronous reset restores the register defaults and the
// idle state and empties the queue.
module motor_button_press_sequencer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [mbps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbps_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  mbps_pkg::in_word_t              in_word,
  output logic                            out_valid,
  input  logic                            out_stall,
  output mbps_pkg::out_word_t             out_word
);

  mbps_pkg::queue_status_t q_status;
  mbps_pkg::cmd_item_t     push_item;
  mbps_pkg::cmd_item_t     head_item;
  logic                    q_push;
  logic                    q_pop;

  // Front end: accept and classify.
  mbps_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .q_status (q_status),
    .q_push   (q_push),
    .q_item   (push_item)
  );

  // Queue that lets each side stall on its own.
  mbps_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .head_item (head_item),
    .status    (q_status)
  );

  // Back end: debounce, command machine, run countdown, output register.
  mbps_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_status  (q_status),
    .q_item    (head_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

[tb/sv/motor_button_press_sequencer_tb.sv]
// Self-checking testbench for the motor button press sequencer.
// Drives the word and configuration ports, predicts every result word in the
// bench itself and compares it field by field; depends on mbps_pkg and the RTL.
`timescale 1ns / 100ps

module motor_button_press_sequencer_tb;

  // Opcodes 5 to 7 have no meaning; the block must leave its state alone.
  localparam logic [2:0] OP_SPARE_A = 3'd5;
  localparam logic [2:0] OP_SPARE_B = 3'd6;
  localparam logic [2:0] OP_SPARE_C = 3'd7;

  // Generous cycle budget; a healthy run needs a small fraction of it.
  localparam int unsigned CYCLE_LIMIT = 500000;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      cfg_we;
  logic [mbps_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [mbps_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic      in_valid;
  logic      in_stall;
  mbps_pkg::in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  mbps_pkg::out_word_t out_word;

  motor_button_press_sequencer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state. These mirror the block's registers and are advanced once
  // for every accepted input word, in acceptance order.
  // ---------------------------------------------------------------------------
  logic [7:0] set_press, set_run, set_btn, set_lim;
  logic [9:0] set_thr;

  logic [2:0] m_state;
  logic [7:0] hold_cnt, pre_cnt;
  logic [7:0] btn1_cnt, btn2_cnt, lim1_cnt, lim2_cnt;
  logic [7:0] run_left;
  logic       run_on, host_hold, dir_cw_sel, dir_ccw_sel, exec_on;
  logic [1:0] lim_bits, lamp_bits, knob_seen;
  logic [3:0] blink_bits;
  logic       dir_low, pwr_low;

  // Result words still owed by the block, oldest first.
  mbps_pkg::out_word_t pending_results[$];
  mbps_pkg::out_word_t head_word;

  int unsigned fail_count  = 0;
  int unsigned sent_words  = 0;
  int unsigned cycle_count = 0;

  // Idling controls. The stall process owns out_stall; the tests only set
  // the knobs below.
  logic tx_idle = 1'b0;
  logic rx_idle = 1'b0;
  int   hold_left  = 0;
  int   burst_left = 0;

  // Emulated drive status lines, which wander a little from tick to tick.
  logic drv_run = 1'b0;
  logic drv_cw  = 1'b0;

  // Both the hold and pre-press counters restart from press_ticks.
  task automatic reload_delays();
    hold_cnt = set_press;
    pre_cnt  = set_press;
  endtask

  // A new command only takes effect from idle, but always marks execute mode
  // and restarts the delays.
  task automatic post_request(input logic [2:0] next_state);
    exec_on = 1'b1;
    if (m_state == mbps_pkg::CMD_REST) m_state = next_state;
    reload_delays();
  endtask

  task automatic start_run(input logic cw);
    run_on      = 1'b1;
    run_left    = set_run;
    dir_cw_sel  = cw;
    dir_ccw_sel = !cw;
    blink_bits  = cw ? {2'b00, mbps_pkg::LAMP_CW} : {2'b00, mbps_pkg::LAMP_CCW};
    lamp_bits   = cw ? mbps_pkg::LAMP_CW : mbps_pkg::LAMP_CCW;
    post_request(cw ? mbps_pkg::CMD_CW : mbps_pkg::CMD_CCW);
  endtask

  // Keep a press line low while the hold counter runs. The counter is
  // decremented even when it reads zero, so it wraps to 255 on release.
  task automatic hold_line(input logic on_power);
    logic was_zero;
    was_zero = (hold_cnt == 8'd0);
    hold_cnt = hold_cnt - 8'd1;
    if (!was_zero) begin
      if (on_power) pwr_low = 1'b1;
      else dir_low = 1'b1;
    end else begin
      if (on_power) pwr_low = 1'b0;
      else dir_low = 1'b0;
      m_state = mbps_pkg::CMD_REST;
    end
  endtask

  // Off and on wait out the pre-press delay, then press the power line only
  // if the drive is not already where we want it.
  task automatic power_gate(input logic need);
    logic was_zero;
    was_zero = (pre_cnt == 8'd0);
    pre_cnt  = pre_cnt - 8'd1;
    if (was_zero) begin
      pre_cnt = 8'd0;
      if (need) hold_line(1'b1);
      else m_state = mbps_pkg::CMD_REST;
    end
  endtask

  task automatic advance_sequencer(input mbps_pkg::in_word_t w,
                                   output mbps_pkg::out_word_t r);
    logic       z;
    logic       ev1, ev2;
    logic [1:0] kb;
    logic       active;
    z   = 1'b0;
    ev1 = 1'b0;
    ev2 = 1'b0;
    kb  = w.knob_channel ? 2'b10 : 2'b01;
    case (w.opcode)
      mbps_pkg::OP_TICK: begin
        // Push button one: a press accepted after the debounce count cancels
        // any command and leaves execute mode.
        if (!w.button_one_level) begin
          z = (btn1_cnt == 8'd0);
          btn1_cnt = btn1_cnt - 8'd1;
        end
        if (!w.button_one_level && z) begin
          ev1 = 1'b1;
          lamp_bits[0] = 1'b1;
          blink_bits = 4'd0;
          exec_on = 1'b0;
          m_state = mbps_pkg::CMD_REST;
          reload_delays();
        end else if (w.button_one_level) begin
          btn1_cnt = set_btn;
        end
        // Push button two asks for off.
        z = 1'b0;
        if (!w.button_two_level) begin
          z = (btn2_cnt == 8'd0);
          btn2_cnt = btn2_cnt - 8'd1;
        end
        if (!w.button_two_level && z) begin
          ev2 = 1'b1;
          lamp_bits[1] = 1'b1;
          blink_bits = 4'd0;
          post_request(mbps_pkg::CMD_OFF);
        end else if (w.button_two_level) begin
          btn2_cnt = set_btn;
        end
        // Limit sensors stop a drive that runs toward them.
        z = 1'b0;
        if (w.sensor_one_level) begin
          z = (lim1_cnt == 8'd0);
          lim1_cnt = lim1_cnt - 8'd1;
        end
        if (w.sensor_one_level && z) begin
          lim_bits[0] = 1'b1;
          lamp_bits[0] = 1'b1;
          blink_bits = 4'd0;
          if (w.drive_running && dir_cw_sel) begin
            exec_on = 1'b1;
            if (m_state == mbps_pkg::CMD_REST) m_state = mbps_pkg::CMD_OFF;
          end
          reload_delays();
        end else if (!w.sensor_one_level) begin
          lim_bits[0] = 1'b0;
          lim1_cnt = set_lim;
        end
        z = 1'b0;
        if (w.sensor_two_level) begin
          z = (lim2_cnt == 8'd0);
          lim2_cnt = lim2_cnt - 8'd1;
        end
        if (w.sensor_two_level && z) begin
          lim_bits[1] = 1'b1;
          lamp_bits[1] = 1'b1;
          blink_bits = 4'd0;
          if (w.drive_running && dir_ccw_sel) begin
            exec_on = 1'b1;
            if (m_state == mbps_pkg::CMD_REST) m_state = mbps_pkg::CMD_OFF;
          end
          reload_delays();
        end else if (!w.sensor_two_level) begin
          lim_bits[1] = 1'b0;
          lim2_cnt = set_lim;
        end
        // Command machine.
        case (m_state)
          mbps_pkg::CMD_REST: begin
            dir_low = 1'b0;
            pwr_low = 1'b0;
            reload_delays();
          end
          mbps_pkg::CMD_CW: begin
            if (!w.drive_cw_mode) hold_line(1'b0);
            else m_state = mbps_pkg::CMD_ON;
          end
          mbps_pkg::CMD_CCW: begin
            if (w.drive_cw_mode) begin
              hold_line(1'b0);
            end else begin
              reload_delays();
              m_state = mbps_pkg::CMD_ON;
            end
          end
          mbps_pkg::CMD_OFF: power_gate(w.drive_running);
          mbps_pkg::CMD_ON:  power_gate(!w.drive_running);
          default: begin
            m_state = mbps_pkg::CMD_REST;
            reload_delays();
          end
        endcase
        // Run countdown; a knob run that expires forces off, a host run only
        // expires once a stop has cleared the host flag.
        if (run_left != 8'd0 && run_on) begin
          run_left = run_left - 8'd1;
        end else if (run_on && !host_hold) begin
          run_on = 1'b0;
          m_state = mbps_pkg::CMD_OFF;
        end
      end
      mbps_pkg::OP_HOST_CW: begin
        host_hold = 1'b1;
        lim_bits = 2'b00;
        start_run(1'b1);
      end
      mbps_pkg::OP_HOST_CCW: begin
        host_hold = 1'b1;
        start_run(1'b0);
      end
      mbps_pkg::OP_HOST_STOP: begin
        host_hold = 1'b0;
        blink_bits = 4'd0;
        post_request(mbps_pkg::CMD_OFF);
      end
      mbps_pkg::OP_KNOB: begin
        // A click arms a run once; after the direction is dropped (an open reading
        // drops it), one click clears the mark before another can arm a run.
        active = w.knob_channel ? dir_ccw_sel : dir_cw_sel;
        if (w.knob_level < set_thr) begin
          if ((knob_seen & kb) != 2'b00) begin
            if (!active) knob_seen = knob_seen & ~kb;
          end else begin
            knob_seen = knob_seen | kb;
            start_run(!w.knob_channel);
          end
        end else begin
          knob_seen = knob_seen | kb;
          if (w.knob_channel) dir_ccw_sel = 1'b0;
          else dir_cw_sel = 1'b0;
        end
      end
      default: ;
    endcase
    r.dir_press_low    = dir_low;
    r.power_press_low  = pwr_low;
    r.command_state    = m_state;
    r.execute_mode     = exec_on;
    r.run_active       = run_on;
    r.led_one          = lamp_bits[0];
    r.led_two          = lamp_bits[1];
    r.blink_mask       = blink_bits;
    r.limit_one        = lim_bits[0];
    r.limit_two        = lim_bits[1];
    r.button_one_event = ev1;
    r.button_two_event = ev2;
  endtask

  // ---------------------------------------------------------------------------
  // Result checking. A result word is taken at a rising edge with out_valid
  // high and out_stall low, and compared with the oldest owed word.
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: %h", out_word);
        fail_count++;
      end else begin
        head_word = pending_results.pop_front();
        check_field("dir_press_low", head_word.dir_press_low, out_word.dir_press_low);
        check_field("power_press_low", head_word.power_press_low,
                    out_word.power_press_low);
        check_field("command_state", head_word.command_state, out_word.command_state);
        check_field("execute_mode", head_word.execute_mode, out_word.execute_mode);
        check_field("run_active", head_word.run_active, out_word.run_active);
        check_field("led_one", head_word.led_one, out_word.led_one);
        check_field("led_two", head_word.led_two, out_word.led_two);
        check_field("blink_mask", head_word.blink_mask, out_word.blink_mask);
        check_field("limit_one", head_word.limit_one, out_word.limit_one);
        check_field("limit_two", head_word.limit_two, out_word.limit_two);
        check_field("button_one_event", head_word.button_one_event,
                    out_word.button_one_event);
        check_field("button_two_event", head_word.button_two_event,
                    out_word.button_two_event);
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("motor_button_press_sequencer test failed");
      $finish;
    end
  end

  // Receiver side. A long hold-off, when requested, is counted down here;
  // otherwise random stall bursts come while rx_idle is set.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left = hold_left - 1;
      end else if (burst_left > 0) begin
        out_stall <= 1'b1;
        burst_left = burst_left - 1;
      end else if (rx_idle && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        burst_left = $urandom_range(1, 16) - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side.
  // ---------------------------------------------------------------------------
  function automatic mbps_pkg::in_word_t pack_word(input logic [2:0] op,
                                                   input logic b1,
                                                   input logic b2, input logic s1,
                                                   input logic s2, input logic run,
                                                   input logic cwm, input logic ch,
                                                   input logic [9:0] lvl);
    mbps_pkg::in_word_t w;
    w.opcode           = op;
    w.button_one_level = b1;
    w.button_two_level = b2;
    w.sensor_one_level = s1;
    w.sensor_two_level = s2;
    w.drive_running    = run;
    w.drive_cw_mode    = cwm;
    w.knob_channel     = ch;
    w.knob_level       = lvl;
    return w;
  endfunction

  // Offer one word, with an optional random gap first, and book its result
  // at the edge where it is taken. Valid stays high between back-to-back
  // words; only the payload changes.
  task automatic send_word(input mbps_pkg::in_word_t w);
    int                  gap;
    mbps_pkg::out_word_t res;
    if (tx_idle && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 16);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_sequencer(w, res);
    pending_results.push_back(res);
    sent_words++;
  endtask

  // A tick with the given button and sensor levels; the drive status drifts
  // and the knob fields, unused on a tick, are random.
  task automatic send_tick(input logic b1, input logic b2, input logic s1,
                           input logic s2);
    if ($urandom_range(0, 4) == 0) drv_run = !drv_run;
    if ($urandom_range(0, 4) == 0) drv_cw = !drv_cw;
    send_word(pack_word(mbps_pkg::OP_TICK, b1, b2, s1, s2, drv_run, drv_cw,
                        1'($urandom_range(0, 1)), 10'($urandom_range(0, 1023))));
  endtask

  // Lower valid and wait until every owed result has arrived, then let the
  // block's pipeline empty.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write all five registers, one per cycle. Only called with the block idle.
  task automatic apply_settings(input logic [7:0] press, input logic [7:0] run,
                                input logic [9:0] thr, input logic [7:0] btn,
                                input logic [7:0] lim);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= mbps_pkg::CFG_PRESS_TICKS;
    cfg_wdata <= {2'b00, press};
    @(negedge clk);
    cfg_index <= mbps_pkg::CFG_RUN_TICKS;
    cfg_wdata <= {2'b00, run};
    @(negedge clk);
    cfg_index <= mbps_pkg::CFG_KNOB_THRESHOLD;
    cfg_wdata <= thr;
    @(negedge clk);
    cfg_index <= mbps_pkg::CFG_BUTTON_RELOAD;
    cfg_wdata <= {2'b00, btn};
    @(negedge clk);
    cfg_index <= mbps_pkg::CFG_LIMIT_RELOAD;
    cfg_wdata <= {2'b00, lim};
    @(negedge clk);
    cfg_we <= 1'b0;
    set_press = press;
    set_run   = run;
    set_thr   = thr;
    set_btn   = btn;
    set_lim   = lim;
  endtask

  // One well-formed stretch of traffic with random content, or a little noise.
  task automatic run_episode();
    logic       ch;
    logic [1:0] mask;
    logic [9:0] lvl;
    int         len;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        // Knob click, let the run proceed, maybe release the contact.
        ch  = 1'($urandom_range(0, 1));
        lvl = (set_thr == 10'd0) ? 10'd0 : 10'($urandom_range(0, set_thr - 1));
        send_word(pack_word(mbps_pkg::OP_KNOB, 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                            drv_run, drv_cw, ch, lvl));
        repeat ($urandom_range(2, 30)) send_tick(1'b1, 1'b1, 1'b0, 1'b0);
        if ($urandom_range(0, 1) == 1) begin
          send_word(pack_word(mbps_pkg::OP_KNOB, 1'b1, 1'b1, 1'b0, 1'b0, drv_run,
                              drv_cw, ch, 10'($urandom_range(set_thr, 1023))));
        end
        repeat ($urandom_range(0, 10)) send_tick(1'b1, 1'b1, 1'b0, 1'b0);
      end
      3, 4: begin
        // Host run, some ticks, stop, and the countdown afterwards.
        send_word(pack_word($urandom_range(0, 1) ? mbps_pkg::OP_HOST_CW :
                                                   mbps_pkg::OP_HOST_CCW,
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                            drv_run, drv_cw, 1'($urandom_range(0, 1)),
                            10'($urandom_range(0, 1023))));
        repeat ($urandom_range(1, 20)) send_tick(1'b1, 1'b1, 1'b0, 1'b0);
        send_word(pack_word(mbps_pkg::OP_HOST_STOP, 1'b1, 1'b1, 1'b0, 1'b0, drv_run,
                            drv_cw, 1'($urandom_range(0, 1)),
                            10'($urandom_range(0, 1023))));
        repeat ($urandom_range(1, 25)) send_tick(1'b1, 1'b1, 1'b0, 1'b0);
      end
      5: begin
        // Hold one or both push buttons long enough to be accepted, mostly.
        mask = 2'($urandom_range(1, 3));
        len = (set_btn < 8'd40 || $urandom_range(0, 3) == 0) ?
              int'(set_btn) + $urandom_range(1, 3) : $urandom_range(1, 10);
        repeat (len) send_tick(!mask[0], !mask[1], 1'b0, 1'b0);
        send_tick(1'b1, 1'b1, 1'b0, 1'b0);
      end
      6: begin
        // Run toward a limit sensor and block it.
        if ($urandom_range(0, 1) == 1) begin
          send_word(pack_word($urandom_range(0, 1) ? mbps_pkg::OP_HOST_CW :
                                                     mbps_pkg::OP_HOST_CCW,
                              1'b1, 1'b1, 1'b0, 1'b0, drv_run, drv_cw, 1'b0, 10'd0));
        end
        drv_run = 1'b1;
        mask = 2'($urandom_range(1, 3));
        len = (set_lim < 8'd40) ? int'(set_lim) + $urandom_range(0, 3) :
              $urandom_range(1, 8);
        repeat (len) send_tick(1'b1, 1'b1, mask[0], mask[1]);
        send_tick(1'b1, 1'b1, 1'b0, 1'b0);
      end
      7: repeat ($urandom_range(1, 10)) send_tick(1'b1, 1'b1, 1'b0, 1'b0);
      8: begin
        // Fully random words, spare opcodes included.
        repeat ($urandom_range(1, 3)) begin
          mbps_pkg::in_word_t w;
          w = mbps_pkg::in_word_t'(20'($urandom));
          send_word(w);
        end
      end
      default: begin
        send_word(pack_word(mbps_pkg::OP_KNOB, 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)), 10'($urandom_range(0, 1023))));
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Field extremes, every opcode, the spare opcodes, button events outside a
  // tick, knob click and release rules, and a button held until its debounce
  // counter reads zero and wraps.
  task automatic test_directed();
    apply_settings(mbps_pkg::PRESS_TICKS_RST, mbps_pkg::RUN_TICKS_RST,
                   mbps_pkg::KNOB_THRESHOLD_RST, mbps_pkg::BUTTON_RELOAD_RST,
                   mbps_pkg::LIMIT_RELOAD_RST);
    send_word(pack_word(mbps_pkg::OP_TICK, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
                        1'b0, 10'd0));
    send_word(pack_word(OP_SPARE_A, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 10'd1023));
    send_word(pack_word(OP_SPARE_B, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 10'd0));
    send_word(pack_word(OP_SPARE_C, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 10'd512));
    // Click on the clockwise contact, click again while active, release, and
    // a click that only disarms because the direction has been dropped.
    send_word(pack_word(mbps_pkg::OP_KNOB, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                        1'b0, 10'd0));
    send_word(pack_word(mbps_pkg::OP_KNOB, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
                        1'b0, 10'd0));
    send_word(pack_word(mbps_pkg::OP_KNOB, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
                        1'b0, 10'd1023));
    send_word(pack_word(mbps_pkg::OP_KNOB, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
                        1'b0, 10'd499));
    // Exactly at the threshold is not a click.
    send_word(pack_word(mbps_pkg::OP_KNOB, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
                        1'b1, 10'd500));
    send_word(pack_word(mbps_pkg::OP_HOST_CCW, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
                        1'b0, 10'd0));
    send_word(pack_word(mbps_pkg::OP_TICK, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1,
                        1'b0, 10'd0));
    send_word(pack_word(mbps_pkg::OP_HOST_CW, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1,
                        1'b1, 10'd1023));
    send_word(pack_word(mbps_pkg::OP_HOST_STOP, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
                        1'b0, 10'd0));
    // Both buttons and both sensors held: the limits trip on the fifth tick,
    // the buttons on the ninth, after which their counters wrap.
    repeat (9) send_word(pack_word(mbps_pkg::OP_TICK, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1,
                                   1'b0, 1'b0, 10'd0));
    send_word(pack_word(mbps_pkg::OP_TICK, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
                        1'b0, 10'd0));
  endtask

  // A knob run whose countdown expires is forced to off, and a host run only
  // expires after a stop.
  task automatic test_run_timeout();
    drain_results();
    apply_settings(8'd1, 8'd2, mbps_pkg::KNOB_THRESHOLD_RST,
                   mbps_pkg::BUTTON_RELOAD_RST, mbps_pkg::LIMIT_RELOAD_RST);
    send_word(pack_word(mbps_pkg::OP_KNOB, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
                        1'b1, 10'd0));
    repeat (5) send_word(pack_word(mbps_pkg::OP_TICK, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1,
                                   1'b1, 1'b0, 10'd0));
    send_word(pack_word(mbps_pkg::OP_HOST_CW, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
                        1'b0, 10'd0));
    repeat (4) send_word(pack_word(mbps_pkg::OP_TICK, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0,
                                   1'b0, 1'b0, 10'd0));
    send_word(pack_word(mbps_pkg::OP_HOST_STOP, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0,
                        1'b0, 10'd0));
    repeat (5) send_word(pack_word(mbps_pkg::OP_TICK, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1,
                                   1'b0, 1'b0, 10'd0));
  endtask

  // Random traffic under one register setting, with idling on both sides.
  task automatic test_random_traffic(input logic [7:0] press, input logic [7:0] run,
                                     input logic [9:0] thr, input logic [7:0] btn,
                                     input logic [7:0] lim, input int unsigned count);
    int unsigned target;
    drain_results();
    apply_settings(press, run, thr, btn, lim);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    target = sent_words + count;
    while (sent_words < target) run_episode();
  endtask

  // The receiver holds off for a long stretch while words keep coming, so the
  // queue fills and in_stall rises; then the sender waits for every result.
  task automatic test_backpressure();
    int unsigned target;
    drain_results();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    hold_left = 120;
    target = sent_words + 40;
    while (sent_words < target) run_episode();
    drain_results();
  endtask

  // Back-to-back words with the receiver always ready.
  task automatic test_steady_stream();
    int unsigned target;
    drain_results();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    target = sent_words + 80;
    while (sent_words < target) run_episode();
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = mbps_pkg::CFG_PRESS_TICKS;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_word   = '0;

    // Predictor starts from the reset state of the block.
    set_press   = mbps_pkg::PRESS_TICKS_RST;
    set_run     = mbps_pkg::RUN_TICKS_RST;
    set_thr     = mbps_pkg::KNOB_THRESHOLD_RST;
    set_btn     = mbps_pkg::BUTTON_RELOAD_RST;
    set_lim     = mbps_pkg::LIMIT_RELOAD_RST;
    m_state     = mbps_pkg::CMD_REST;
    hold_cnt    = mbps_pkg::PRESS_TICKS_RST;
    pre_cnt     = mbps_pkg::PRESS_TICKS_RST;
    btn1_cnt    = mbps_pkg::BUTTON_RELOAD_RST;
    btn2_cnt    = mbps_pkg::BUTTON_RELOAD_RST;
    lim1_cnt    = mbps_pkg::LIMIT_RELOAD_RST;
    lim2_cnt    = mbps_pkg::LIMIT_RELOAD_RST;
    run_left    = 8'd0;
    run_on      = 1'b0;
    host_hold   = 1'b0;
    dir_cw_sel  = 1'b0;
    dir_ccw_sel = 1'b0;
    exec_on     = 1'b0;
    lim_bits    = 2'b00;
    lamp_bits   = 2'b00;
    blink_bits  = 4'd0;
    knob_seen   = 2'b00;
    dir_low     = 1'b0;
    pwr_low     = 1'b0;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_run_timeout();
    test_random_traffic(mbps_pkg::PRESS_TICKS_RST, mbps_pkg::RUN_TICKS_RST,
                        mbps_pkg::KNOB_THRESHOLD_RST, mbps_pkg::BUTTON_RELOAD_RST,
                        mbps_pkg::LIMIT_RELOAD_RST, 250);
    test_random_traffic(8'd0, 8'd0, 10'd0, 8'd0, 8'd0, 200);
    test_backpressure();
    test_random_traffic(8'd255, 8'd255, 10'd1023, 8'd255, 8'd255, 150);
    repeat (3) begin
      test_random_traffic(8'($urandom_range(0, 6)), 8'($urandom_range(0, 30)),
                          10'($urandom_range(0, 1023)), 8'($urandom_range(0, 10)),
                          8'($urandom_range(0, 6)), 150);
    end
    test_steady_stream();

    // Wait out every owed result, then keep watching for stray words.
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("motor_button_press_sequencer test passed");
    end else begin
      $display("motor_button_press_sequencer test failed");
    end
    $finish;
  end

endmodule
